FILE: rtl/plhc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plhc_pkg: shared types and constants of the pinned lru handle cache
// entry geometry, request and result codes and the structs between the
// sequencer, the key/handle store and the shared compare unit
// ----------------------------------------------------------------------------
package plhc_pkg;

    localparam int ENTRIES     = 32;
    localparam int KEY_BITS    = 32;
    localparam int HANDLE_BITS = 16;
    localparam int IDX_BITS    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_BITS    = $clog2(ENTRIES + 1);
    localparam int CFG_BITS    = 6;

    localparam int S_TDATA_BITS = 72;
    localparam int M_TDATA_BITS = 40;

    // request kinds
    localparam logic [1:0] REQ_OPEN      = 2'd0;
    localparam logic [1:0] REQ_CLOSE     = 2'd1;
    localparam logic [1:0] REQ_CLOSE_ALL = 2'd2;

    // result status codes
    localparam logic [3:0] STS_HIT        = 4'd0;
    localparam logic [3:0] STS_FILLED     = 4'd1;
    localparam logic [3:0] STS_REPLACED   = 4'd2;
    localparam logic [3:0] STS_BYP_OPEN   = 4'd3;
    localparam logic [3:0] STS_BAD_NAME   = 4'd4;
    localparam logic [3:0] STS_OPEN_FAIL  = 4'd5;
    localparam logic [3:0] STS_BUSY       = 4'd6;
    localparam logic [3:0] STS_NO_SLOT    = 4'd7;
    localparam logic [3:0] STS_RELEASED   = 4'd8;
    localparam logic [3:0] STS_CLOSED     = 4'd9;
    localparam logic [3:0] STS_NOT_FOUND  = 4'd10;
    localparam logic [3:0] STS_BYP_CLOSE  = 4'd11;
    localparam logic [3:0] STS_CA_EVICT   = 4'd12;
    localparam logic [3:0] STS_CA_DONE    = 4'd13;

    // store write port
    typedef struct packed {
        logic                   en;
        logic [IDX_BITS-1:0]    addr;
        logic [KEY_BITS-1:0]    key;
        logic [HANDLE_BITS-1:0] handle;
    } store_wr_t;

    // operands of the compare unit
    typedef struct packed {
        logic [1:0]             mode;
        logic [KEY_BITS-1:0]    key;
        logic [HANDLE_BITS-1:0] handle;
        logic [KEY_BITS-1:0]    rd_key;
        logic [HANDLE_BITS-1:0] rd_handle;
        logic                   valid;
        logic                   pinned;
        logic                   slot_nz;
    } cmp_req_t;

    typedef struct packed {
        logic hit;
        logic victim;
    } cmp_res_t;

endpackage : plhc_pkg
`default_nettype wire

FILE: rtl/plhc_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plhc_store: key and handle memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module plhc_store (
    input  wire logic                            aclk,
    input  wire plhc_pkg::store_wr_t             wr,
    input  wire logic                            rd_en,
    input  wire logic [plhc_pkg::IDX_BITS-1:0]   rd_addr,
    output logic      [plhc_pkg::KEY_BITS-1:0]   rd_key,
    output logic      [plhc_pkg::HANDLE_BITS-1:0] rd_handle
);
    import plhc_pkg::*;

    logic [KEY_BITS+HANDLE_BITS-1:0] entry_mem [ENTRIES];
    logic [KEY_BITS+HANDLE_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            entry_mem[wr.addr] <= {wr.key, wr.handle};
        end
        if (rd_en) begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign rd_key    = rd_data_reg[KEY_BITS+HANDLE_BITS-1:HANDLE_BITS];
    assign rd_handle = rd_data_reg[HANDLE_BITS-1:0];

endmodule : plhc_store
`default_nettype wire

FILE: rtl/plhc_cmp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plhc_cmp: shared compare unit
// matches one slot against the request key or handle, or takes any valid slot on a
// close-all sweep, and flags replacement candidates
// ----------------------------------------------------------------------------
module plhc_cmp (
    input  wire plhc_pkg::cmp_req_t req,
    output plhc_pkg::cmp_res_t      res
);
    import plhc_pkg::*;

    logic eq;

    always_comb begin
        unique case (req.mode)
            REQ_OPEN:      eq = (req.rd_key == req.key);
            REQ_CLOSE:     eq = (req.rd_handle == req.handle);
            default:       eq = 1'b1; // sweep takes every valid slot
        endcase
        res.hit    = req.valid && eq;
        res.victim = req.slot_nz && !req.pinned;
    end

endmodule : plhc_cmp
`default_nettype wire

FILE: rtl/pinned_lru_handle_cache.sv
`default_nettype none
// requests are taken one at a time; the slots are scanned in turn through the one
//   read port and the one compare unit, and a result stall holds the sequencer;
//   a bad name or a bypass is answered without a scan of the slots
// reset: valid, pinned and doomed marks cleared at once, cache_entries back to 30,
//   no clearing pass; key and handle memory content is left as it is
// ----------------------------------------------------------------------------
// pinned_lru_handle_cache: fully associative cache of open backing handles
// a small sequencer scans the slots through one compare unit, shifts entries down to
// insert in front and gives one or more results per open, close or close-all request
// ----------------------------------------------------------------------------
module pinned_lru_handle_cache (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration: cache_entries
    input  wire logic                                cfg_wr_en,
    input  wire logic [plhc_pkg::CFG_BITS-1:0]       cfg_wr_data,
    // request channel
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // lookup_key[31:0], name_bad[32], backing_ok[33], new_handle[49:34],
    // close_handle[65:50], zero fill above
    input  wire logic [plhc_pkg::S_TDATA_BITS-1:0]   s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]                          s_tuser,
    // result channel
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // handle_out[15:0], release_backing[16], released_handle[32:17], zero fill above
    output logic [plhc_pkg::M_TDATA_BITS-1:0]        m_tdata,
    // status[3:0]
    output logic [3:0]                               m_tuser,
    output logic                                     m_tlast
);
    import plhc_pkg::*;

    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(30);

    typedef struct packed {
        logic [3:0]             status;
        logic [HANDLE_BITS-1:0] handle_out;
        logic                   rel;
        logic [HANDLE_BITS-1:0] rel_handle;
        logic                   last;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_CHECK,
        ST_DECIDE,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_INSTALL,
        ST_EMIT,
        ST_SWEEP_NEXT
    } state_t;

    function automatic res_t mk_res(logic [3:0] st, logic [HANDLE_BITS-1:0] hout,
                                    logic rel, logic [HANDLE_BITS-1:0] rh, logic last);
        res_t r;
        r.status     = st;
        r.handle_out = hout;
        r.rel        = rel;
        r.rel_handle = rh;
        r.last       = last;
        return r;
    endfunction

    // sequencer and request registers
    state_t                  state_reg, state_next;
    logic [1:0]              req_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic                    bad_reg, ok_reg;
    logic [HANDLE_BITS-1:0]  nh_reg, ch_reg;
    logic [CNT_BITS-1:0]     n_reg, n_next;
    logic [CNT_BITS-1:0]     idx_reg, idx_next;

    // miss bookkeeping collected during the open scan
    logic                    have_empty_reg, have_empty_next;
    logic [IDX_BITS-1:0]     empty_idx_reg, empty_idx_next;
    logic                    have_victim_reg, have_victim_next;
    logic [IDX_BITS-1:0]     victim_idx_reg, victim_idx_next;
    logic [HANDLE_BITS-1:0]  victim_h_reg, victim_h_next;
    logic [IDX_BITS-1:0]     mv_reg, mv_next;

    res_t                    res_reg, res_next;
    res_t                    out_reg, out_next;
    logic                    m_tvalid_reg, m_tvalid_next;

    // per-slot marks, in flip-flops
    logic [ENTRIES-1:0]      valid_reg, valid_next;
    logic [ENTRIES-1:0]      pinned_reg, pinned_next;
    logic [ENTRIES-1:0]      doomed_reg, doomed_next;

    logic [CFG_BITS-1:0]     cache_entries_reg;

    // store and compare unit
    store_wr_t               st_wr;
    logic                    st_rd_en;
    logic [IDX_BITS-1:0]     st_rd_addr;
    logic [KEY_BITS-1:0]     st_rd_key;
    logic [HANDLE_BITS-1:0]  st_rd_handle;
    cmp_req_t                cmp_req;
    cmp_res_t                cmp_res;

    logic                    s_accept;
    logic                    out_free;
    logic [IDX_BITS-1:0]     slot;
    logic                    last_slot;
    logic [CNT_BITS-1:0]     n_live;
    logic [IDX_BITS-1:0]     target;

    plhc_store u_store (
        .aclk      (aclk),
        .wr        (st_wr),
        .rd_en     (st_rd_en),
        .rd_addr   (st_rd_addr),
        .rd_key    (st_rd_key),
        .rd_handle (st_rd_handle)
    );

    plhc_cmp u_cmp (
        .req (cmp_req),
        .res (cmp_res)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {7'd0, out_reg.rel_handle, out_reg.rel, out_reg.handle_out};

    // slot count saturates at the table size
    assign n_live = (cache_entries_reg > CFG_BITS'(ENTRIES)) ? CNT_BITS'(ENTRIES)
                                                             : CNT_BITS'(cache_entries_reg);

    assign slot      = idx_reg[IDX_BITS-1:0];
    assign last_slot = ((idx_reg + CNT_BITS'(1)) == n_reg);
    assign target    = have_empty_reg ? empty_idx_reg : victim_idx_reg;

    always_comb begin
        cmp_req.mode      = req_reg;
        cmp_req.key       = key_reg;
        cmp_req.handle    = ch_reg;
        cmp_req.rd_key    = st_rd_key;
        cmp_req.rd_handle = st_rd_handle;
        cmp_req.valid     = valid_reg[slot];
        cmp_req.pinned    = pinned_reg[slot];
        cmp_req.slot_nz   = (slot != '0);
    end

    always_comb begin
        state_next       = state_reg;
        n_next           = n_reg;
        idx_next         = idx_reg;
        have_empty_next  = have_empty_reg;
        empty_idx_next   = empty_idx_reg;
        have_victim_next = have_victim_reg;
        victim_idx_next  = victim_idx_reg;
        victim_h_next    = victim_h_reg;
        mv_next          = mv_reg;
        res_next         = res_reg;
        out_next         = out_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        valid_next       = valid_reg;
        pinned_next      = pinned_reg;
        doomed_next      = doomed_reg;

        st_wr.en     = 1'b0;
        st_wr.addr   = '0;
        st_wr.key    = key_reg;
        st_wr.handle = nh_reg;
        st_rd_en     = 1'b0;
        st_rd_addr   = slot;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    n_next     = n_live;
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH: begin
                idx_next         = '0;
                have_empty_next  = 1'b0;
                have_victim_next = 1'b0;
                unique case (req_reg)
                    REQ_OPEN: begin
                        if (bad_reg) begin
                            res_next   = mk_res(STS_BAD_NAME, '0, 1'b0, '0, 1'b1);
                            state_next = ST_EMIT;
                        end else if (n_reg == '0) begin
                            // bypass: hand the backing open straight through
                            res_next   = ok_reg ? mk_res(STS_BYP_OPEN, nh_reg, 1'b0, '0, 1'b1)
                                                : mk_res(STS_OPEN_FAIL, '0, 1'b0, '0, 1'b1);
                            state_next = ST_EMIT;
                        end else begin
                            state_next = ST_READ;
                        end
                    end
                    REQ_CLOSE: begin
                        if (n_reg == '0) begin
                            res_next   = mk_res(STS_BYP_CLOSE, '0, 1'b1, ch_reg, 1'b1);
                            state_next = ST_EMIT;
                        end else begin
                            state_next = ST_READ;
                        end
                    end
                    REQ_CLOSE_ALL: begin
                        if (n_reg == '0) begin
                            res_next   = mk_res(STS_CA_DONE, '0, 1'b0, '0, 1'b1);
                            state_next = ST_EMIT;
                        end else begin
                            state_next = ST_READ;
                        end
                    end
                    default: begin
                        // unused request kind: dropped without a result
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_READ: begin
                st_rd_en   = 1'b1;
                st_rd_addr = slot;
                state_next = ST_CHECK;
            end

            ST_CHECK: begin
                unique case (req_reg)
                    REQ_OPEN: begin
                        if (cmp_res.hit) begin
                            if (pinned_reg[slot]) begin
                                res_next = mk_res(STS_BUSY, '0, 1'b0, '0, 1'b1);
                            end else begin
                                pinned_next[slot] = 1'b1;
                                res_next = mk_res(STS_HIT, st_rd_handle, 1'b0, '0, 1'b1);
                            end
                            state_next = ST_EMIT;
                        end else begin
                            // first empty slot wins, deepest unpinned slot wins
                            if (!valid_reg[slot] && !have_empty_reg) begin
                                have_empty_next = 1'b1;
                                empty_idx_next  = slot;
                            end
                            if (cmp_res.victim) begin
                                have_victim_next = 1'b1;
                                victim_idx_next  = slot;
                                victim_h_next    = st_rd_handle;
                            end
                            if (last_slot) begin
                                state_next = ST_DECIDE;
                            end else begin
                                idx_next   = idx_reg + CNT_BITS'(1);
                                state_next = ST_READ;
                            end
                        end
                    end
                    REQ_CLOSE: begin
                        if (cmp_res.hit) begin
                            if (doomed_reg[slot]) begin
                                valid_next[slot]  = 1'b0;
                                pinned_next[slot] = 1'b0;
                                doomed_next[slot] = 1'b0;
                                res_next = mk_res(STS_CLOSED, '0, 1'b1, ch_reg, 1'b1);
                            end else begin
                                pinned_next[slot] = 1'b0;
                                res_next = mk_res(STS_RELEASED, '0, 1'b0, '0, 1'b1);
                            end
                            state_next = ST_EMIT;
                        end else if (last_slot) begin
                            res_next   = mk_res(STS_NOT_FOUND, '0, 1'b0, '0, 1'b1);
                            state_next = ST_EMIT;
                        end else begin
                            idx_next   = idx_reg + CNT_BITS'(1);
                            state_next = ST_READ;
                        end
                    end
                    default: begin
                        // close-all sweep
                        if (cmp_res.hit && !pinned_reg[slot]) begin
                            valid_next[slot]  = 1'b0;
                            pinned_next[slot] = 1'b0;
                            doomed_next[slot] = 1'b0;
                            res_next   = mk_res(STS_CA_EVICT, '0, 1'b1, st_rd_handle, 1'b0);
                            state_next = ST_EMIT;
                        end else begin
                            if (cmp_res.hit) begin
                                doomed_next[slot] = 1'b1;
                            end
                            state_next = ST_SWEEP_NEXT;
                        end
                    end
                endcase
            end

            ST_SWEEP_NEXT: begin
                if (last_slot) begin
                    res_next   = mk_res(STS_CA_DONE, '0, 1'b0, '0, 1'b1);
                    state_next = ST_EMIT;
                end else begin
                    idx_next   = idx_reg + CNT_BITS'(1);
                    state_next = ST_READ;
                end
            end

            ST_DECIDE: begin
                if (!have_empty_reg && !have_victim_reg) begin
                    res_next   = mk_res(STS_NO_SLOT, '0, 1'b0, '0, 1'b1);
                    state_next = ST_EMIT;
                end else if (!ok_reg) begin
                    res_next   = mk_res(STS_OPEN_FAIL, '0, 1'b0, '0, 1'b1);
                    state_next = ST_EMIT;
                end else begin
                    res_next = have_empty_reg
                             ? mk_res(STS_FILLED, nh_reg, 1'b0, '0, 1'b1)
                             : mk_res(STS_REPLACED, nh_reg, 1'b1, victim_h_reg, 1'b1);
                    // marks move down in one step, memory follows entry by entry
                    for (int j = 1; j < ENTRIES; j++) begin
                        if (IDX_BITS'(j) <= target) begin
                            valid_next[j]  = valid_reg[j-1];
                            pinned_next[j] = pinned_reg[j-1];
                            doomed_next[j] = doomed_reg[j-1];
                        end
                    end
                    valid_next[0]  = 1'b1;
                    pinned_next[0] = 1'b1;
                    doomed_next[0] = 1'b0;
                    if (target == '0) begin
                        state_next = ST_INSTALL;
                    end else begin
                        mv_next    = target;
                        state_next = ST_MOVE_RD;
                    end
                end
            end

            ST_MOVE_RD: begin
                st_rd_en   = 1'b1;
                st_rd_addr = mv_reg - IDX_BITS'(1);
                state_next = ST_MOVE_WR;
            end

            ST_MOVE_WR: begin
                st_wr.en     = 1'b1;
                st_wr.addr   = mv_reg;
                st_wr.key    = st_rd_key;
                st_wr.handle = st_rd_handle;
                if (mv_reg == IDX_BITS'(1)) begin
                    state_next = ST_INSTALL;
                end else begin
                    mv_next    = mv_reg - IDX_BITS'(1);
                    state_next = ST_MOVE_RD;
                end
            end

            ST_INSTALL: begin
                st_wr.en     = 1'b1;
                st_wr.addr   = '0;
                st_wr.key    = key_reg;
                st_wr.handle = nh_reg;
                state_next   = ST_EMIT;
            end

            ST_EMIT: begin
                if (out_free) begin
                    out_next      = res_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = res_reg.last ? ST_IDLE : ST_SWEEP_NEXT;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            m_tvalid_reg      <= 1'b0;
            valid_reg         <= '0;
            pinned_reg        <= '0;
            doomed_reg        <= '0;
            cache_entries_reg <= CFG_RESET;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            valid_reg    <= valid_next;
            pinned_reg   <= pinned_next;
            doomed_reg   <= doomed_next;
            if (cfg_wr_en) begin
                cache_entries_reg <= cfg_wr_data;
            end
        end

        // payload, no reset needed
        if (s_accept) begin
            req_reg <= s_tuser;
            key_reg <= s_tdata[31:0];
            bad_reg <= s_tdata[32];
            ok_reg  <= s_tdata[33];
            nh_reg  <= s_tdata[49:34];
            ch_reg  <= s_tdata[65:50];
        end
        n_reg           <= n_next;
        idx_reg         <= idx_next;
        have_empty_reg  <= have_empty_next;
        empty_idx_reg   <= empty_idx_next;
        have_victim_reg <= have_victim_next;
        victim_idx_reg  <= victim_idx_next;
        victim_h_reg    <= victim_h_next;
        mv_reg          <= mv_next;
        res_reg         <= res_next;
        out_reg         <= out_next;
    end

endmodule : pinned_lru_handle_cache
`default_nettype wire
